@@ rtl/core/rlt_pkg.sv @@
// ----------------------------------------------------------------------------
// rlt_pkg
// Shared types and codes of the raster line tracer: channel payloads,
// register indexes, probe directions and the controller/datapath link.
// ----------------------------------------------------------------------------
`default_nettype none

package rlt_pkg;

   localparam int COORD_W     = 9;
   localparam int TGT_W       = COORD_W + 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_FETCH = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIT_COLOR    = 2'd2;

   localparam logic [COORD_W-1:0]    DIM_RESET       = 9'd256;
   localparam logic [CSR_DATA_W-1:0] LIT_COLOR_RESET = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        action;
      logic [31:0] pixel_rgba;
      logic [7:0]  pixel_col;
      logic [7:0]  pixel_row;
   } req_data_type;

   typedef struct packed {
      logic [7:0] point_col;
      logic [7:0] point_row;
      logic       line_end;
      logic       done_res;
   } rsp_data_type;

   typedef enum logic [3:0] {
      DIR_CENTER,
      DIR_UP_LEFT,
      DIR_UP,
      DIR_UP_RIGHT,
      DIR_LEFT,
      DIR_RIGHT,
      DIR_DOWN_RIGHT,
      DIR_DOWN,
      DIR_DOWN_LEFT
   } probe_dir_type;

   typedef struct packed {
      logic          load_wr;
      logic          restart;
      logic          scan_next_row;
      logic          scan_take;
      logic          base_trace;
      logic          mark_start;
      logic          take_move;
      logic          probe;
      probe_dir_type dir;
      logic          emit;
      logic          emit_last;
      logic          emit_done;
      logic          emit_adv;
   } cmd_type;

   typedef struct packed {
      logic lit;
      logic near_border;
      logic scan_row_end;
      logic scan_col_end;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/core/raster_line_tracer_top.sv @@
// ----------------------------------------------------------------------------
// raster_line_tracer_top
// Line tracer over a one-bit lit map of a loaded RGBA image.
//
// Input items on req_* either load one pixel (action 0) or fetch the next
// traced point (action 1). Each fetch yields exactly one result item on
// rsp_*: a point with its end-of-line flag, or a done item. Loads yield none
// and restart tracing. Registers must be written through csr_* only while
// idle; the block itself does not enforce this. A fetch is a series of map
// probes, one at a time over the single map port: each is issued in a
// request state and checked in a check state once the registered data of
// the single-port lit map RAM is out. A traced point needs its probes plus
// the scan that finds its line start.
// A held result sits in the output register; a new item is taken while it
// waits, and a fetch finishes once the register frees. rsp_stall only
// holds the pending result. Reset restores default registers and the scan
// position; map contents are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module raster_line_tracer_top #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire rlt_pkg::req_data_type           req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output rlt_pkg::rsp_data_type                rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [rlt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rlt_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   rlt_pkg::cmd_type cmd;
   rlt_pkg::sts_type sts;

   rlt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   rlt_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire

@@ rtl/core/rlt_ram.sv @@
// ----------------------------------------------------------------------------
// rlt_ram
// Generic single-port RAM with one write or read address per cycle and a
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rlt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/rlt_datapath.sv @@
// ----------------------------------------------------------------------------
// rlt_datapath
// Lit map, configuration registers, scan and trace positions, neighbor
// probe address generation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rlt_datapath #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire rlt_pkg::req_data_type               req_data,
   output rlt_pkg::rsp_data_type                    rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [rlt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [rlt_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire rlt_pkg::cmd_type                    cmd,
   output rlt_pkg::sts_type                         sts
);

   localparam int CW       = rlt_pkg::COORD_W;
   localparam int TW       = rlt_pkg::TGT_W;
   localparam int RamDepth = MAX_WIDTH * MAX_HEIGHT;
   localparam int AddrW    = $clog2(RamDepth);
   localparam logic [AddrW-1:0] RowStride = AddrW'(MAX_WIDTH);

   logic [CW-1:0] width_ff, height_ff;
   logic [31:0]   lit_color_ff;
   logic [CW-1:0] scan_row_ff, scan_col_ff;
   logic [CW-1:0] trace_row_ff, trace_col_ff;
   logic [CW-1:0] base_row_ff, base_col_ff;
   logic [CW-1:0] cand_row_ff, cand_col_ff;
   logic [TW-1:0] tgt_row_ff, tgt_col_ff;
   logic          inb_ff;
   rlt_pkg::rsp_data_type rsp_data_ff;

   logic [CW-1:0]    eff_w, eff_h;
   logic [TW-1:0]    b_row, b_col;
   logic [TW-1:0]    prb_row, prb_col;
   logic             prb_inb;
   logic             load_ok;
   logic [AddrW-1:0] ram_addr;
   logic [0:0]       ram_rd;

   assign eff_w = (32'(width_ff) > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : width_ff;
   assign eff_h = (32'(height_ff) > 32'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : height_ff;

   assign b_row = {1'b0, base_row_ff};
   assign b_col = {1'b0, base_col_ff};

   always_comb begin
      prb_row = b_row;
      prb_col = b_col;
      case (cmd.dir)
         rlt_pkg::DIR_CENTER: begin
         end
         rlt_pkg::DIR_UP_LEFT: begin
            prb_row = b_row - TW'(1);
            prb_col = b_col - TW'(1);
         end
         rlt_pkg::DIR_UP: begin
            prb_row = b_row - TW'(1);
         end
         rlt_pkg::DIR_UP_RIGHT: begin
            prb_row = b_row - TW'(1);
            prb_col = b_col + TW'(1);
         end
         rlt_pkg::DIR_LEFT: begin
            prb_col = b_col - TW'(1);
         end
         rlt_pkg::DIR_RIGHT: begin
            prb_col = b_col + TW'(1);
         end
         rlt_pkg::DIR_DOWN_RIGHT: begin
            prb_row = b_row + TW'(1);
            prb_col = b_col + TW'(1);
         end
         rlt_pkg::DIR_DOWN: begin
            prb_row = b_row + TW'(1);
         end
         rlt_pkg::DIR_DOWN_LEFT: begin
            prb_row = b_row + TW'(1);
            prb_col = b_col - TW'(1);
         end
         default: begin
         end
      endcase
   end

   // negative offsets wrap to large values and fail the bound check
   assign prb_inb = (prb_row < {1'b0, eff_h}) && (prb_col < {1'b0, eff_w});

   assign load_ok = (32'(req_data.pixel_col) < 32'(MAX_WIDTH)) &&
                    (32'(req_data.pixel_row) < 32'(MAX_HEIGHT));

   always_comb begin
      if (cmd.load_wr) begin
         ram_addr = AddrW'(req_data.pixel_row) * RowStride + AddrW'(req_data.pixel_col);
      end else begin
         ram_addr = AddrW'(prb_row[CW-1:0]) * RowStride + AddrW'(prb_col[CW-1:0]);
      end
   end

   rlt_ram #(
      .WIDTH (1),
      .DEPTH (RamDepth)
   ) u_lit_map (
      .clock   (clock),
      .wr_en   (cmd.load_wr && load_ok),
      .addr    (ram_addr),
      .wr_data (req_data.pixel_rgba == lit_color_ff),
      .rd_data (ram_rd)
   );

   assign sts.lit          = inb_ff && ram_rd[0];
   assign sts.near_border  = (tgt_row_ff + TW'(1) >= {1'b0, eff_h}) ||
                             (tgt_row_ff <= TW'(1)) ||
                             (tgt_col_ff + TW'(1) >= {1'b0, eff_w}) ||
                             (tgt_col_ff <= TW'(1));
   assign sts.scan_row_end = ({1'b0, scan_row_ff} + TW'(1)) >= {1'b0, eff_h};
   assign sts.scan_col_end = ({1'b0, scan_col_ff} + TW'(1)) >= {1'b0, eff_w};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= rlt_pkg::DIM_RESET;
         height_ff    <= rlt_pkg::DIM_RESET;
         lit_color_ff <= rlt_pkg::LIT_COLOR_RESET;
         scan_row_ff  <= CW'(1);
         scan_col_ff  <= CW'(1);
         trace_row_ff <= '0;
         trace_col_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rlt_pkg::CSR_IMAGE_WIDTH:  width_ff     <= csr_wdata[CW-1:0];
               rlt_pkg::CSR_IMAGE_HEIGHT: height_ff    <= csr_wdata[CW-1:0];
               rlt_pkg::CSR_LIT_COLOR:    lit_color_ff <= csr_wdata[31:0];
               default: begin
               end
            endcase
         end
         if (cmd.restart) begin
            scan_row_ff  <= CW'(1);
            scan_col_ff  <= CW'(1);
            trace_row_ff <= '0;
            trace_col_ff <= '0;
         end
         if (cmd.scan_next_row) begin
            scan_row_ff <= scan_row_ff + CW'(1);
            scan_col_ff <= CW'(1);
         end
         if (cmd.scan_take) begin
            scan_col_ff <= scan_col_ff + CW'(1);
         end
         if (cmd.mark_start) begin
            trace_row_ff <= base_row_ff;
            trace_col_ff <= base_col_ff;
         end
         if (cmd.emit && cmd.emit_adv) begin
            trace_row_ff <= cand_row_ff;
            trace_col_ff <= cand_col_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_take) begin
         base_row_ff <= scan_row_ff;
         base_col_ff <= scan_col_ff;
      end
      if (cmd.base_trace) begin
         base_row_ff <= trace_row_ff;
         base_col_ff <= trace_col_ff;
      end
      if (cmd.take_move) begin
         cand_row_ff <= tgt_row_ff[CW-1:0];
         cand_col_ff <= tgt_col_ff[CW-1:0];
         base_row_ff <= tgt_row_ff[CW-1:0];
         base_col_ff <= tgt_col_ff[CW-1:0];
      end
      if (cmd.probe) begin
         tgt_row_ff <= prb_row;
         tgt_col_ff <= prb_col;
         inb_ff     <= prb_inb;
      end
      if (cmd.emit) begin
         if (cmd.emit_done) begin
            rsp_data_ff.point_col <= '0;
            rsp_data_ff.point_row <= '0;
            rsp_data_ff.line_end  <= 1'b0;
            rsp_data_ff.done_res  <= 1'b1;
         end else begin
            rsp_data_ff.point_col <= trace_col_ff[7:0];
            rsp_data_ff.point_row <= trace_row_ff[7:0];
            rsp_data_ff.line_end  <= cmd.emit_last;
            rsp_data_ff.done_res  <= 1'b0;
         end
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/rlt_ctrl.sv @@
// ----------------------------------------------------------------------------
// rlt_ctrl
// Controller: item handshake, scan and trace sequencing over single map
// probes, and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rlt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_action,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rlt_pkg::cmd_type      cmd,
   input  wire rlt_pkg::sts_type sts
);

   localparam logic [2:0] StartLast = 3'd4;
   localparam logic [1:0] MoveLast  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_START_REQ,
      ST_START_CHK,
      ST_MOVE_REQ,
      ST_MOVE_CHK,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PURP_START,
      PURP_FIRST,
      PURP_AHEAD
   } purpose_type;

   state_type   state_ff, state_in;
   purpose_type purpose_ff, purpose_in;
   logic        tracing_ff, tracing_in;
   logic        finished_ff, finished_in;
   logic [2:0]  pidx_ff, pidx_in;
   logic [1:0]  midx_ff, midx_in;
   logic        emit_last_ff, emit_last_in;
   logic        emit_done_ff, emit_done_in;
   logic        emit_adv_ff, emit_adv_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_free;

   function automatic rlt_pkg::probe_dir_type start_dir(input logic [2:0] idx);
      rlt_pkg::probe_dir_type d;
      case (idx)
         3'd0:    d = rlt_pkg::DIR_CENTER;
         3'd1:    d = rlt_pkg::DIR_UP_LEFT;
         3'd2:    d = rlt_pkg::DIR_UP;
         3'd3:    d = rlt_pkg::DIR_UP_RIGHT;
         default: d = rlt_pkg::DIR_LEFT;
      endcase
      return d;
   endfunction

   function automatic rlt_pkg::probe_dir_type move_dir(input logic [1:0] idx);
      rlt_pkg::probe_dir_type d;
      case (idx)
         2'd0:    d = rlt_pkg::DIR_RIGHT;
         2'd1:    d = rlt_pkg::DIR_DOWN_RIGHT;
         2'd2:    d = rlt_pkg::DIR_DOWN;
         default: d = rlt_pkg::DIR_DOWN_LEFT;
      endcase
      return d;
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      purpose_in   = purpose_ff;
      tracing_in   = tracing_ff;
      finished_in  = finished_ff;
      pidx_in      = pidx_ff;
      midx_in      = midx_ff;
      emit_last_in = emit_last_ff;
      emit_done_in = emit_done_ff;
      emit_adv_in  = emit_adv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.dir      = rlt_pkg::DIR_CENTER;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == rlt_pkg::ACT_FETCH) begin
                  state_in = ST_DISPATCH;
               end else begin
                  cmd.load_wr = 1'b1;
                  cmd.restart = 1'b1;
                  tracing_in  = 1'b0;
                  finished_in = 1'b0;
               end
            end
         end
         ST_DISPATCH: begin
            if (tracing_ff) begin
               cmd.base_trace = 1'b1;
               midx_in        = '0;
               purpose_in     = PURP_FIRST;
               state_in       = ST_MOVE_REQ;
            end else if (finished_ff) begin
               emit_done_in = 1'b1;
               emit_last_in = 1'b0;
               emit_adv_in  = 1'b0;
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_row_end) begin
               finished_in  = 1'b1;
               emit_done_in = 1'b1;
               emit_last_in = 1'b0;
               emit_adv_in  = 1'b0;
               state_in     = ST_EMIT;
            end else if (sts.scan_col_end) begin
               cmd.scan_next_row = 1'b1;
            end else begin
               cmd.scan_take = 1'b1;
               pidx_in       = '0;
               state_in      = ST_START_REQ;
            end
         end
         ST_START_REQ: begin
            cmd.probe = 1'b1;
            cmd.dir   = start_dir(pidx_ff);
            state_in  = ST_START_CHK;
         end
         ST_START_CHK: begin
            // center must be lit, the four earlier neighbors unlit
            if (sts.lit != (pidx_ff == '0)) begin
               state_in = ST_SCAN;
            end else if (pidx_ff == StartLast) begin
               midx_in    = '0;
               purpose_in = PURP_START;
               state_in   = ST_MOVE_REQ;
            end else begin
               pidx_in  = pidx_ff + 3'd1;
               state_in = ST_START_REQ;
            end
         end
         ST_MOVE_REQ: begin
            cmd.probe = 1'b1;
            cmd.dir   = move_dir(midx_ff);
            state_in  = ST_MOVE_CHK;
         end
         ST_MOVE_CHK: begin
            if (sts.lit) begin
               if (purpose_ff == PURP_AHEAD) begin
                  emit_done_in = 1'b0;
                  emit_last_in = 1'b0;
                  emit_adv_in  = 1'b1;
                  state_in     = ST_EMIT;
               end else begin
                  cmd.take_move  = 1'b1;
                  cmd.mark_start = (purpose_ff == PURP_START);
                  tracing_in     = 1'b1;
                  if (sts.near_border) begin
                     tracing_in   = 1'b0;
                     emit_done_in = 1'b0;
                     emit_last_in = 1'b1;
                     emit_adv_in  = 1'b0;
                     state_in     = ST_EMIT;
                  end else begin
                     midx_in    = '0;
                     purpose_in = PURP_AHEAD;
                     state_in   = ST_MOVE_REQ;
                  end
               end
            end else if (midx_ff == MoveLast) begin
               if (purpose_ff == PURP_AHEAD) begin
                  tracing_in   = 1'b0;
                  emit_done_in = 1'b0;
                  emit_last_in = 1'b1;
                  emit_adv_in  = 1'b0;
                  state_in     = ST_EMIT;
               end else begin
                  tracing_in = 1'b0;
                  state_in   = ST_SCAN;
               end
            end else begin
               midx_in  = midx_ff + 2'd1;
               state_in = ST_MOVE_REQ;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = emit_last_ff;
               cmd.emit_done = emit_done_ff;
               cmd.emit_adv  = emit_adv_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         purpose_ff   <= PURP_START;
         tracing_ff   <= 1'b0;
         finished_ff  <= 1'b0;
         pidx_ff      <= '0;
         midx_ff      <= '0;
         emit_last_ff <= 1'b0;
         emit_done_ff <= 1'b0;
         emit_adv_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         purpose_ff   <= purpose_in;
         tracing_ff   <= tracing_in;
         finished_ff  <= finished_in;
         pidx_ff      <= pidx_in;
         midx_ff      <= midx_in;
         emit_last_ff <= emit_last_in;
         emit_done_ff <= emit_done_in;
         emit_adv_ff  <= emit_adv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_move_chk_after_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE_CHK) |-> ($past(state_ff) == ST_MOVE_REQ))
      else $error("move check without a probe issued");

   a_finished_not_tracing: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !tracing_ff)
      else $error("scan finished while a line is open");

   a_load_restarts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_action == rlt_pkg::ACT_LOAD)
      |=> (!tracing_ff && !finished_ff))
      else $error("load did not restart tracing");

   a_done_not_tracing: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && emit_done_ff) |-> !tracing_ff)
      else $error("done item sent while tracing");

endmodule

`default_nettype wire
